// ===== hdl/modular_exponentiation_macros.svh =====
// assertion macros for the modular exponentiation block
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define MODEXP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every rising clock edge outside reset
`define MODEXP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/modexp_pkg.sv =====
// shared types and constants for the modular exponentiation block
`default_nettype none
package modexp_pkg;

  // default datapath width, operands are one bit narrower
  localparam int DEF_WIDTH = 64;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQ_LOAD,
    ST_SQ_RUN,
    ST_MB_LOAD,
    ST_MB_RUN,
    ST_NEXT,
    ST_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic red_step;
    logic red_store;
    logic mul_load;
    logic mul_sel_base;
    logic mul_step;
    logic mul_store;
    logic exp_shift;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic mod_zero;
    logic exp_bit;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hdl/modexp_dp.sv =====
// datapath: operand registers, shared modular double-and-add step, exponent register
`default_nettype none
module modexp_dp
  import modexp_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [WIDTH-2:0] base,
  input  wire logic [WIDTH-2:0] modulus,
  input  wire logic             exp_we,
  input  wire logic [WIDTH-2:0] exp_data,
  input  wire dp_cmd_t          cmd,
  output dp_status_t            status,
  output logic      [WIDTH-2:0] result,
  output logic                  modulus_error
);

  localparam int OPW = WIDTH - 1;

  logic [OPW-1:0] exponent;
  logic [OPW-1:0] exp_sh;
  logic [OPW-1:0] mod_r;
  logic [OPW-1:0] acc;
  logic [OPW-1:0] mop_a;
  logic [OPW-1:0] mop_b;
  logic [OPW-1:0] base_r;
  logic [OPW-1:0] pow_r;
  logic           mzero;

  logic [WIDTH-1:0] m_ext;
  logic [WIDTH-1:0] dbl;
  logic [WIDTH-1:0] dbl_red;
  logic [OPW-1:0]   addend;
  logic [WIDTH-1:0] sum;
  logic [WIDTH-1:0] sum_red;
  logic [OPW-1:0]   step_val;

  // one step: double (shifting in a dividend bit when reducing), reduce, add, reduce
  always_comb begin
    m_ext    = {1'b0, mod_r};
    dbl      = {acc, cmd.red_step & mop_b[OPW-1]};
    dbl_red  = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    addend   = (cmd.mul_step && mop_b[OPW-1]) ? mop_a : '0;
    sum      = {1'b0, dbl_red[OPW-1:0]} + {1'b0, addend};
    sum_red  = (sum >= m_ext) ? (sum - m_ext) : sum;
    step_val = sum_red[OPW-1:0];
  end

  // private exponent register
  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= '0;
    end else if (exp_we) begin
      exponent <= exp_data;
    end
  end

  // operand and accumulator registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mod_r  <= modulus;
      mop_b  <= base;
      acc    <= '0;
      exp_sh <= exponent;
      mzero  <= (modulus == '0);
      pow_r  <= (modulus == OPW'(1)) ? '0 : OPW'(1);
    end
    if (cmd.red_step || cmd.mul_step) begin
      acc   <= step_val;
      mop_b <= {mop_b[OPW-2:0], 1'b0};
    end
    if (cmd.red_store) begin
      base_r <= step_val;
    end
    if (cmd.mul_load) begin
      acc   <= '0;
      mop_a <= cmd.mul_sel_base ? base_r : pow_r;
      mop_b <= pow_r;
    end
    if (cmd.mul_store) begin
      pow_r <= step_val;
    end
    if (cmd.exp_shift) begin
      exp_sh <= {exp_sh[OPW-2:0], 1'b0};
    end
  end

  // status and result
  assign status.mod_zero = (modulus == '0);
  assign status.exp_bit  = exp_sh[OPW-1];
  assign result          = mzero ? '0 : pow_r;
  assign modulus_error   = mzero;

endmodule
`default_nettype wire

// ===== hdl/modexp_ctrl.sv =====
// controller: sequences base reduction and square-and-multiply over the exponent bits
`default_nettype none
module modexp_ctrl
  import modexp_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd,
  output logic            busy,
  output logic            done
);

  localparam int OPW = WIDTH - 1;
  localparam int CW  = $clog2(OPW);
  localparam logic [CW-1:0] LAST = CW'(OPW - 1);

  state_t        state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] ecnt, ecnt_next;

  // state and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      ecnt  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ecnt  <= ecnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ecnt_next  = ecnt;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          ecnt_next  = '0;
          state_next = status.mod_zero ? ST_DONE : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.red_step = 1'b1;
        if (cnt == LAST) begin
          cmd.red_store = 1'b1;
          state_next    = ST_SQ_LOAD;
        end
        cnt_next = (cnt == LAST) ? '0 : cnt + 1'b1;
      end
      ST_SQ_LOAD: begin
        cmd.mul_load = 1'b1;
        state_next   = ST_SQ_RUN;
      end
      ST_SQ_RUN: begin
        cmd.mul_step = 1'b1;
        if (cnt == LAST) begin
          cmd.mul_store = 1'b1;
          state_next    = status.exp_bit ? ST_MB_LOAD : ST_NEXT;
        end
        cnt_next = (cnt == LAST) ? '0 : cnt + 1'b1;
      end
      ST_MB_LOAD: begin
        cmd.mul_load     = 1'b1;
        cmd.mul_sel_base = 1'b1;
        state_next       = ST_MB_RUN;
      end
      ST_MB_RUN: begin
        cmd.mul_step = 1'b1;
        if (cnt == LAST) begin
          cmd.mul_store = 1'b1;
          state_next    = ST_NEXT;
        end
        cnt_next = (cnt == LAST) ? '0 : cnt + 1'b1;
      end
      ST_NEXT: begin
        cmd.exp_shift = 1'b1;
        if (ecnt == LAST) begin
          state_next = ST_DONE;
        end else begin
          ecnt_next  = ecnt + 1'b1;
          state_next = ST_SQ_LOAD;
        end
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/modular_exponentiation.sv =====
// Modular exponentiation, base^exponent mod modulus, W = WIDTH-1 bit operands.
// Base reduction first, then a square for every exponent bit and a multiply for each set bit;
// each runs one modular double-and-add step per cycle over every multiplier bit.
// Zero modulus: result strobe in the cycle after the request is taken.
// One request at a time, busy until done; the next request is taken the cycle after done.
// Synchronous active-high reset clears the controller and the exponent register to 0.
`default_nettype none
`include "modular_exponentiation_macros.svh"
module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [WIDTH-2:0] base,
  input  wire logic [WIDTH-2:0] modulus,
  output logic                  done,
  output logic      [WIDTH-2:0] result,
  output logic                  modulus_error,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [WIDTH-2:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  modexp_ctrl #(
    .WIDTH(WIDTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  modexp_dp #(
    .WIDTH(WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .base         (base),
    .modulus      (modulus),
    .exp_we       (cfg_valid & cfg_ready),
    .exp_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result       (result),
    .modulus_error(modulus_error)
  );

  // checks
  `MODEXP_ASSERT_NOW(a_done_busy, done, busy, "result strobe outside a request")
  `MODEXP_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted request did not start")
  `MODEXP_ASSERT_NOW(a_err_zero, done && modulus_error, result == '0, "error result not zero")
  `MODEXP_ASSERT_NEXT(a_done_once, done, !done, "result strobe longer than one cycle")

endmodule
`default_nettype wire

// ===== dv/modexp_power_check.sv =====
`timescale 1ns / 1ps
// checker for the modular exponentiation block: predicts each power and compares the results
module modexp_power_check
  import modexp_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic [WIDTH-2:0] base,
  input  logic [WIDTH-2:0] modulus,
  input  logic             done,
  input  logic [WIDTH-2:0] result,
  input  logic             modulus_error,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [WIDTH-2:0] cfg_data,
  output int               fail_count,
  output int               pending
);

  localparam int W = WIDTH - 1;

  typedef struct packed {
    logic [W-1:0] value;
    logic         zero_mod;
  } power_t;

  // private exponent as last written
  logic [W-1:0] exponent_copy;
  power_t       pending_powers[$];
  power_t       oldest;
  int           mismatches;

  // (x + y) mod m, both operands already below m
  function automatic logic [W-1:0] add_mod(logic [W-1:0] x, logic [W-1:0] y,
                                           logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  // shift-and-add modular product
  function automatic logic [W-1:0] mul_mod(logic [W-1:0] a, logic [W-1:0] b,
                                           logic [W-1:0] m);
    logic [W-1:0] r;
    r = '0;
    for (int i = W - 1; i >= 0; i--) begin
      r = add_mod(r, r, m);
      if (b[i]) r = add_mod(r, a, m);
    end
    return r;
  endfunction

  // left-to-right square and multiply, base reduced first
  function automatic logic [W-1:0] pow_mod(logic [W-1:0] b, logic [W-1:0] e,
                                           logic [W-1:0] m);
    logic [W-1:0] r;
    logic [W-1:0] br;
    r  = (m == 1) ? '0 : 1;
    br = b % m;
    for (int i = W - 1; i >= 0; i--) begin
      r = mul_mod(r, r, m);
      if (e[i]) r = mul_mod(r, br, m);
    end
    return r;
  endfunction

  function automatic power_t predict_power(logic [W-1:0] b, logic [W-1:0] m,
                                           logic [W-1:0] e);
    power_t p;
    if (m == 0) begin
      p.value    = '0;
      p.zero_mod = 1'b1;
    end else begin
      p.value    = pow_mod(b, e, m);
      p.zero_mod = 1'b0;
    end
    return p;
  endfunction

  // compare results first, then record new requests, then register writes
  always @(posedge clk) begin
    if (rst) begin
      exponent_copy = '0;
    end else begin
      if (done) begin
        if (pending_powers.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual result=%h error=%b",
                   $time, result, modulus_error);
        end else begin
          oldest = pending_powers.pop_front();
          if (result !== oldest.value) begin
            mismatches++;
            $display("%0t: result mismatch, expected %h actual %h",
                     $time, oldest.value, result);
          end
          if (modulus_error !== oldest.zero_mod) begin
            mismatches++;
            $display("%0t: modulus_error mismatch, expected %b actual %b",
                     $time, oldest.zero_mod, modulus_error);
          end
        end
      end
      if (start && !busy)
        pending_powers.push_back(predict_power(base, modulus, exponent_copy));
      if (cfg_valid && cfg_ready) exponent_copy = cfg_data;
    end
    pending    <= pending_powers.size();
    fail_count <= mismatches;
  end

endmodule

// ===== dv/tb_modular_exponentiation.sv =====
`timescale 1ns / 1ps
// testbench top for the modular exponentiation block: stimulus, watchdog and verdict
module tb_modular_exponentiation;
  import modexp_pkg::*;

  localparam int WIDTH       = DEF_WIDTH;
  localparam int W           = WIDTH - 1;
  localparam int STALL_LIMIT = 50000;
  localparam logic [W-1:0] ALL_ONES = {W{1'b1}};

  logic         clk;
  logic         rst;
  logic         start;
  logic         busy;
  logic [W-1:0] base;
  logic [W-1:0] modulus;
  logic         done;
  logic [W-1:0] result;
  logic         modulus_error;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [W-1:0] cfg_data;
  int           fail_count;
  int           pending;
  int           sender_idle;
  int           stall_cycles;

  modular_exponentiation #(.WIDTH(WIDTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .base         (base),
    .modulus      (modulus),
    .done         (done),
    .result       (result),
    .modulus_error(modulus_error),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  modexp_power_check #(.WIDTH(WIDTH)) checker_i (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .base         (base),
    .modulus      (modulus),
    .done         (done),
    .result       (result),
    .modulus_error(modulus_error),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // operand mix: edges, small values, single bits and full random words
  function automatic logic [W-1:0] rand_operand();
    logic [63:0]  raw;
    logic [W-1:0] v;
    raw = {$urandom, $urandom};
    v   = raw[W-1:0];
    case ($urandom_range(9))
      0: v = '0;
      1: v = 1;
      2: v = ALL_ONES;
      3: v = $urandom_range(1000, 2);
      4: begin
        v = '0;
        v[$urandom_range(W - 1)] = 1'b1;
      end
      5: v = ALL_ONES - $urandom_range(1000);
      default: ;
    endcase
    return v;
  endfunction

  // hold one request until the block takes it, start dropping at random
  task automatic send(input logic [W-1:0] b, input logic [W-1:0] m);
    logic go;
    do begin
      @(negedge clk);
      go = ($urandom_range(99) >= sender_idle);
      start   <= go;
      base    <= b;
      modulus <= m;
      @(posedge clk);
    end while (!(go && !busy));
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  // register write, only once the block is idle
  task automatic set_exponent(input logic [W-1:0] e);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= e;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // watchdog on cycles without any accepted transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL modular_exponentiation");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    base         = '0;
    modulus      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    sender_idle  = 36;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // exponent still at its reset value of zero
    send('0, '0);
    send('0, 5);
    send(ALL_ONES, 1);
    send(ALL_ONES, ALL_ONES);

    // all exponent bits set, slowest case
    set_exponent(ALL_ONES);
    send(ALL_ONES, ALL_ONES);
    send(ALL_ONES - 1, ALL_ONES);
    send(2, ALL_ONES);
    send(ALL_ONES, '0);
    send(5, 1);
    send(1, 2);
    send(3, {1'b1, {(W - 1){1'b0}}});
    send({(W / 2 + 1){2'b01}}, {(W / 2 + 1){2'b10}});

    // exponent of one: result is the reduced base
    set_exponent(1);
    send(ALL_ONES, 12345);
    send(100, 7);
    send('0, '0);
    send(6, 6);

    // sparse exponent against a large prime
    set_exponent(65537);
    send(2, {2'b00, {(W - 2){1'b1}}});
    send(ALL_ONES, {2'b00, {(W - 2){1'b1}}});
    send('0, 97);

    // random part, three idle settings, exponent changed every dozen requests
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle = (phase == 0) ? 36 : (phase == 1) ? 68 : 0;
      for (int n = 0; n < 27; n++) begin
        if (n % 12 == 0) set_exponent(rand_operand());
        send(rand_operand(), rand_operand());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS modular_exponentiation");
    end else begin
      $display("FAIL modular_exponentiation");
    end
    $finish;
  end

endmodule
